### design/pacavg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the periodic angle color average block.
// No dependencies; every other design file refers to this package by scope.

package pacavg_pkg;

    // Field widths fixed by the item formats.
    localparam int ANGLE_W   = 16;
    localparam int REF_W     = 9;
    localparam int LEVEL_W   = 16;
    localparam int COUNT_W   = 21;

    // Configuration register map.
    localparam int NUM_REFS  = 6;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED_PHI   = 3'd0,
        REG_RED_PSI   = 3'd1,
        REG_GREEN_PHI = 3'd2,
        REG_GREEN_PSI = 3'd3,
        REG_BLUE_PHI  = 3'd4,
        REG_BLUE_PSI  = 3'd5
    } pacavg_reg_idx_t;

    localparam logic signed [REF_W-1:0] REF_RESET [NUM_REFS] = '{
        -9'sd120, 9'sd120, -9'sd60, -9'sd60, 9'sd60, 9'sd60
    };

    // Channel indexing: red, green, blue.
    localparam int NUM_CHANNELS = 3;
    localparam int CHAN_W       = 2;
    localparam logic [CHAN_W-1:0] LAST_CHAN = 2'd2;

    // One shared step unit resolves one result bit per cycle.
    localparam int STEPS  = 16;
    localparam int STEP_W = 4;

    // Geometry: full turn in degrees and the squared maximum distance,
    // (sqrt(2) * 180)^2 in whole degrees.
    localparam int FULL_TURN   = 360;
    localparam int DIST_SQ_MAX = 64800;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_SQUARE,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_ACCUM,
        ST_DIV_LOAD,
        ST_DIV,
        ST_PUBLISH
    } pacavg_state_t;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic capture;
        logic axis_diff;
        logic square;
        logic root_load;
        logic step;
        logic root_mode;
        logic accum;
        logic div_load;
        logic publish;
    } pacavg_ctrl_t;

endpackage

### design/pacavg_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample items and result items.
// Depends on pacavg_pkg for the field widths.

interface pacavg_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pacavg_pkg::ANGLE_W-1:0] phi_angle;
    logic signed [pacavg_pkg::ANGLE_W-1:0] psi_angle;
    logic                                  last_sample;

    modport source (output valid, phi_angle, psi_angle, last_sample, input ready);
    modport sink   (input valid, phi_angle, psi_angle, last_sample, output ready);
endinterface

interface pacavg_result_if;
    logic                             valid;
    logic                             ready;
    logic [pacavg_pkg::LEVEL_W-1:0]   red_level;
    logic [pacavg_pkg::LEVEL_W-1:0]   green_level;
    logic [pacavg_pkg::LEVEL_W-1:0]   blue_level;
    logic [pacavg_pkg::COUNT_W-1:0]   samples_used;

    modport source (output valid, red_level, green_level, blue_level, samples_used,
                    input ready);
    modport sink   (input valid, red_level, green_level, blue_level, samples_used,
                    output ready);
endinterface

### design/periodic_angle_color_average_core.sv
`timescale 1ns / 1ps
// An accepted item is processed one channel at a time, most of the work on the shared root/divide
// unit; the next item is not accepted until all three channels of it are accumulated.
// An item arriving after the sample limit is reached is accepted and dropped at once.
// A last item then runs the three divisions on the same unit and hands its result to the output
// register, where it is held until taken; the hand-off waits while that register is full.
// Reset (rst_n low, asynchronous) clears sums, count and output valid and loads the default
// reference points; no clearing pass is needed.

module periodic_angle_color_average_core #(
    parameter int MAX_SAMPLES     = 1048576,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    pacavg_sample_if.sink                       sample_in,
    pacavg_result_if.source                     result_out,
    input  logic                                cfg_write,
    input  logic [pacavg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pacavg_pkg::REF_W-1:0]        cfg_data
);

    // Derived widths.
    localparam int TW  = $clog2(MAX_SAMPLES + 1);               // sample count
    localparam int SW  = pacavg_pkg::LEVEL_W + TW;              // channel sums
    localparam int DW  = ((ANGLE_FRAC_BITS + 10 > pacavg_pkg::ANGLE_W) ?
                          ANGLE_FRAC_BITS + 10 : pacavg_pkg::ANGLE_W) + 2; // axis difference
    localparam int SQW = 2 * DW + 1;                            // squared distance
    localparam int RW  = 35 + 2 * ANGLE_FRAC_BITS;              // root residual
    localparam int UW  = (RW > SW) ? RW : SW;                   // shared unit width
    localparam int CW  = (SQW > UW) ? SQW : UW;                 // range compare width
    localparam int LW  = pacavg_pkg::LEVEL_W;

    localparam logic signed [DW-1:0] PERIOD =
        DW'(pacavg_pkg::FULL_TURN) <<< ANGLE_FRAC_BITS;
    localparam logic [UW-1:0] DEN  = UW'(pacavg_pkg::DIST_SQ_MAX) << (2 * ANGLE_FRAC_BITS);
    localparam logic [UW-1:0] DEN3 = DEN + (DEN << 1);
    localparam logic [TW-1:0] TALLY_MAX = TW'(MAX_SAMPLES);
    localparam logic [pacavg_pkg::STEP_W-1:0] STEP_LAST =
        pacavg_pkg::STEP_W'(pacavg_pkg::STEPS - 1);

    // Sequencer and control registers.
    pacavg_pkg::pacavg_state_t          state_reg, state_next;
    pacavg_pkg::pacavg_ctrl_t           ctrl;
    logic [pacavg_pkg::CHAN_W-1:0]      chan_reg;
    logic                               axis_reg;
    logic [pacavg_pkg::STEP_W-1:0]      step_reg;
    logic [TW-1:0]                      tally_reg;
    logic [SW-1:0]                      sum_reg [pacavg_pkg::NUM_CHANNELS];
    logic                               out_valid_reg;
    logic signed [pacavg_pkg::REF_W-1:0] cfg_reg [pacavg_pkg::NUM_REFS];

    // Payload registers.
    logic signed [pacavg_pkg::ANGLE_W-1:0] phi_reg, psi_reg;
    logic                               last_reg;
    logic [DW-1:0]                      mag_reg;
    logic [SQW-1:0]                     dsq_reg;
    logic                               over_reg;
    logic [UW-1:0]                      rem_reg;
    logic [UW-1:0]                      trial_reg;
    logic [LW-1:0]                      q_reg;
    logic [LW-1:0]                      avg_reg [pacavg_pkg::NUM_CHANNELS];
    logic [LW-1:0]                      out_level_reg [pacavg_pkg::NUM_CHANNELS];
    logic [pacavg_pkg::COUNT_W-1:0]     out_count_reg;

    logic step_last;
    logic chan_last;
    logic has_room;
    logic slot_free;

    assign step_last = (step_reg == STEP_LAST);
    assign chan_last = (chan_reg == pacavg_pkg::LAST_CHAN);
    assign has_room  = (tally_reg < TALLY_MAX);
    assign slot_free = !out_valid_reg || result_out.ready;

    // Configuration writes; indexes beyond the map are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pacavg_pkg::NUM_REFS; i++)
            begin
                cfg_reg[i] <= pacavg_pkg::REF_RESET[i];
            end
        end
        else if (cfg_write && (cfg_index <= pacavg_pkg::REG_BLUE_PSI))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pacavg_pkg::ST_IDLE:
            begin
                if (sample_in.valid)
                begin
                    priority if (has_room)
                        state_next = pacavg_pkg::ST_DIST;
                    else if (sample_in.last_sample)
                        state_next = pacavg_pkg::ST_DIV_LOAD;
                    else
                        state_next = pacavg_pkg::ST_IDLE;
                end
            end
            pacavg_pkg::ST_DIST:
                state_next = pacavg_pkg::ST_SQUARE;
            pacavg_pkg::ST_SQUARE:
                state_next = axis_reg ? pacavg_pkg::ST_ROOT_LOAD : pacavg_pkg::ST_DIST;
            pacavg_pkg::ST_ROOT_LOAD:
                state_next = pacavg_pkg::ST_ROOT;
            pacavg_pkg::ST_ROOT:
            begin
                if (step_last)
                    state_next = pacavg_pkg::ST_ACCUM;
            end
            pacavg_pkg::ST_ACCUM:
            begin
                priority if (!chan_last)
                    state_next = pacavg_pkg::ST_DIST;
                else if (last_reg)
                    state_next = pacavg_pkg::ST_DIV_LOAD;
                else
                    state_next = pacavg_pkg::ST_IDLE;
            end
            pacavg_pkg::ST_DIV_LOAD:
                state_next = pacavg_pkg::ST_DIV;
            pacavg_pkg::ST_DIV:
            begin
                if (step_last)
                    state_next = chan_last ? pacavg_pkg::ST_PUBLISH : pacavg_pkg::ST_DIV_LOAD;
            end
            pacavg_pkg::ST_PUBLISH:
            begin
                if (slot_free)
                    state_next = pacavg_pkg::ST_IDLE;
            end
            default:
                state_next = pacavg_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        ctrl            = '0;
        sample_in.ready = 1'b0;
        unique case (state_reg)
            pacavg_pkg::ST_IDLE:
            begin
                sample_in.ready = 1'b1;
                ctrl.capture    = sample_in.valid;
            end
            pacavg_pkg::ST_DIST:      ctrl.axis_diff = 1'b1;
            pacavg_pkg::ST_SQUARE:    ctrl.square    = 1'b1;
            pacavg_pkg::ST_ROOT_LOAD: ctrl.root_load = 1'b1;
            pacavg_pkg::ST_ROOT:
            begin
                ctrl.step      = 1'b1;
                ctrl.root_mode = 1'b1;
            end
            pacavg_pkg::ST_ACCUM:     ctrl.accum     = 1'b1;
            pacavg_pkg::ST_DIV_LOAD:  ctrl.div_load  = 1'b1;
            pacavg_pkg::ST_DIV:       ctrl.step      = 1'b1;
            pacavg_pkg::ST_PUBLISH:   ctrl.publish   = slot_free;
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // Periodic axis distance: smallest of |d|, |d + 360|, |d - 360|.
    logic signed [pacavg_pkg::ANGLE_W-1:0] sample_sel;
    logic signed [pacavg_pkg::REF_W-1:0]   ref_sel;
    logic signed [DW-1:0] diff_c, diff_p, diff_n;
    logic [DW-1:0]        mag_c, mag_p, mag_n, mag_min;

    assign sample_sel = axis_reg ? psi_reg : phi_reg;
    assign ref_sel    = cfg_reg[{chan_reg, axis_reg}];
    assign diff_c     = DW'(sample_sel) - (DW'(ref_sel) <<< ANGLE_FRAC_BITS);
    assign diff_p     = diff_c + PERIOD;
    assign diff_n     = diff_c - PERIOD;
    assign mag_c      = diff_c[DW-1] ? DW'(-diff_c) : DW'(diff_c);
    assign mag_p      = diff_p[DW-1] ? DW'(-diff_p) : DW'(diff_p);
    assign mag_n      = diff_n[DW-1] ? DW'(-diff_n) : DW'(diff_n);

    always_comb
    begin
        mag_min = mag_c;
        if (mag_p < mag_min)
            mag_min = mag_p;
        if (mag_n < mag_min)
            mag_min = mag_n;
    end

    // Squared distance, summed over the two axes.
    logic [2*DW-1:0] mag_sq;
    logic [SQW-1:0]  dsq_next;

    assign mag_sq   = mag_reg * mag_reg;
    assign dsq_next = (axis_reg ? dsq_reg : '0) + SQW'(mag_sq);

    // Shared compare-subtract unit. Root mode finds floor(sqrt(dsq * 2^32 / DEN)) one bit
    // a step with the residual scaled by DEN; divide mode is restoring division of a sum.
    logic [UW-1:0] opnd;
    logic [UW:0]   diff_u;
    logic          take;
    logic [UW-1:0] rem_next;
    logic [UW-1:0] trial_next;
    logic [UW-1:0] trial_dbl;
    logic [LW-1:0] q_next;

    assign opnd      = ctrl.root_mode ? {rem_reg[UW-3:0], 2'b00} : rem_reg;
    assign diff_u    = {1'b0, opnd} - {1'b0, trial_reg};
    assign take      = !diff_u[UW];
    assign rem_next  = take ? diff_u[UW-1:0] : opnd;
    assign trial_dbl = trial_reg << 1;
    assign q_next    = {q_reg[LW-2:0], take};

    always_comb
    begin
        if (!ctrl.root_mode)
            trial_next = trial_reg >> 1;
        else if (take)
            trial_next = trial_dbl + DEN3;
        else
            trial_next = trial_dbl - DEN;
    end

    // Channel weight: 1 - distance / max, saturated at all ones, zero when out of range.
    logic [LW-1:0] weight;

    always_comb
    begin
        priority if (over_reg)
            weight = '0;
        else if (q_reg == '0)
            weight = '1;
        else
            weight = LW'({1'b1, {LW{1'b0}}} - {1'b0, q_reg});
    end

    // Control registers: state, counters, sums and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pacavg_pkg::ST_IDLE;
            chan_reg      <= '0;
            axis_reg      <= 1'b0;
            step_reg      <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < pacavg_pkg::NUM_CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (ctrl.capture)
            begin
                chan_reg <= '0;
                axis_reg <= 1'b0;
            end
            if (ctrl.square && !axis_reg)
                axis_reg <= 1'b1;

            if (ctrl.root_load || ctrl.div_load)
                step_reg <= '0;
            else if (ctrl.step)
                step_reg <= step_reg + 1'b1;

            // Close one channel of a sample; after blue, count the sample.
            if (ctrl.accum)
            begin
                sum_reg[chan_reg] <= sum_reg[chan_reg] + SW'(weight);
                axis_reg          <= 1'b0;
                if (chan_last)
                begin
                    chan_reg  <= '0;
                    tally_reg <= tally_reg + 1'b1;
                end
                else
                begin
                    chan_reg <= chan_reg + 1'b1;
                end
            end

            // Advance to the next channel's division.
            if (ctrl.step && !ctrl.root_mode && step_last)
                chan_reg <= chan_last ? '0 : chan_reg + 1'b1;

            // Hand the averages to the output register and start a new set.
            if (ctrl.publish)
            begin
                out_valid_reg <= 1'b1;
                tally_reg     <= '0;
                for (int i = 0; i < pacavg_pkg::NUM_CHANNELS; i++)
                begin
                    sum_reg[i] <= '0;
                end
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            phi_reg  <= sample_in.phi_angle;
            psi_reg  <= sample_in.psi_angle;
            last_reg <= sample_in.last_sample;
        end
        if (ctrl.axis_diff)
            mag_reg <= mag_min;
        if (ctrl.square)
            dsq_reg <= dsq_next;

        if (ctrl.root_load)
        begin
            over_reg  <= (CW'(dsq_reg) >= CW'(DEN));
            rem_reg   <= UW'(dsq_reg);
            trial_reg <= DEN;
            q_reg     <= '0;
        end
        else if (ctrl.div_load)
        begin
            rem_reg   <= UW'(sum_reg[chan_reg]);
            trial_reg <= UW'(tally_reg) << (LW - 1);
            q_reg     <= '0;
        end
        else if (ctrl.step)
        begin
            rem_reg   <= rem_next;
            trial_reg <= trial_next;
            q_reg     <= q_next;
        end

        if (ctrl.step && !ctrl.root_mode && step_last)
            avg_reg[chan_reg] <= q_next;

        if (ctrl.publish)
        begin
            for (int i = 0; i < pacavg_pkg::NUM_CHANNELS; i++)
            begin
                out_level_reg[i] <= avg_reg[i];
            end
            out_count_reg <= pacavg_pkg::COUNT_W'(tally_reg);
        end
    end

    // Result channel.
    assign result_out.valid        = out_valid_reg;
    assign result_out.red_level    = out_level_reg[0];
    assign result_out.green_level  = out_level_reg[1];
    assign result_out.blue_level   = out_level_reg[2];
    assign result_out.samples_used = out_count_reg;

endmodule
